// ===== design/bchr_pkg.sv =====
// Shared constants, codes and types for the two-error BCH repair block.
`timescale 1ns / 1ps

package bchr_pkg;

  localparam int MAX_WORD_BITS = 31;
  localparam int POLY_BITS     = 12;
  localparam int SYN_BITS      = 11;
  localparam int IDX_BITS      = 5;
  localparam int DEG_BITS      = 4;
  localparam int WB_BITS       = 5;
  localparam int ME_BITS       = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int STATUS_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_GEN_POLY   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORD_BITS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ERRORS = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_CLEAN = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ONE   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TWO   = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FAIL  = 2'd3;

  localparam logic [POLY_BITS-1:0]   GEN_POLY_RESET   = 12'd1207;
  localparam logic [WB_BITS-1:0]     WORD_BITS_RESET  = 5'd31;
  localparam logic [ME_BITS-1:0]     MAX_ERRORS_RESET = 2'd2;

  typedef struct packed {
    logic                     we;
    logic [IDX_BITS-1:0]      addr;
    logic [MAX_WORD_BITS-1:0] data;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_DIV,
    TOP_SRCH,
    TOP_HOLD
  } top_state_t;

  typedef enum logic [2:0] {
    SR_IDLE,
    SR_SINGLE,
    SR_LOAD,
    SR_PAIR,
    SR_DRAIN,
    SR_DONE
  } srch_state_t;

endpackage

// ===== design/bchr_div.sv =====
// Bit-serial GF(2) divider: syndrome of the word and the table of bit remainders.
`timescale 1ns / 1ps

module bchr_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [bchr_pkg::MAX_WORD_BITS-1:0]    word,
  input  logic [bchr_pkg::WB_BITS-1:0]          n,
  input  logic [bchr_pkg::POLY_BITS-1:0]        gen_poly,
  output logic                                  done,
  output logic [bchr_pkg::MAX_WORD_BITS-1:0]    rem,
  output logic [bchr_pkg::MAX_WORD_BITS-1:0]    masked,
  output bchr_pkg::tbl_wr_t                     tbl_wr
);

  localparam int W = bchr_pkg::MAX_WORD_BITS;
  localparam int P = bchr_pkg::POLY_BITS;

  logic                              busy;
  logic [bchr_pkg::IDX_BITS-1:0]     k;
  logic [W-1:0]                      sr;
  logic [W-1:0]                      pw;
  logic [W-1:0]                      pw_next;
  logic [W-1:0]                      rem_next;
  logic [bchr_pkg::DEG_BITS-1:0]     deg;
  logic                              poly_nz;
  logic [bchr_pkg::IDX_BITS-1:0]     pos;
  logic                              feed;

  function automatic logic [W-1:0] lfsr_step(input logic [W-1:0] r, input logic b,
                                             input logic [bchr_pkg::DEG_BITS-1:0] d,
                                             input logic nz, input logic [P-1:0] g);
    logic [W-1:0] t;
    logic [P-1:0] t_low;
    t     = {r[W-2:0], b};
    t_low = t[P-1:0];
    if (nz && t_low[d]) begin
      t = t ^ {{(W-P){1'b0}}, g};
    end
    return t;
  endfunction

  always_comb begin
    deg = '0;
    for (int b = 0; b < P; b++) begin
      if (gen_poly[b]) begin
        deg = bchr_pkg::DEG_BITS'(b);
      end
    end
  end

  assign poly_nz  = (gen_poly != '0);
  assign pos      = bchr_pkg::IDX_BITS'(W - 1) - k;
  assign feed     = sr[W-1] & (pos < n);
  assign rem_next = lfsr_step(rem, feed, deg, poly_nz, gen_poly);
  assign pw_next  = lfsr_step(pw, (k == '0), deg, poly_nz, gen_poly);

  assign tbl_wr.we   = busy && (k < n);
  assign tbl_wr.addr = n - 5'd1 - k;
  assign tbl_wr.data = pw_next;
  assign masked      = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 5'd1;
        if (k == bchr_pkg::IDX_BITS'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= word;
      rem <= '0;
      pw  <= '0;
    end else if (busy) begin
      sr  <= {sr[W-2:0], feed};
      rem <= rem_next;
      pw  <= pw_next;
    end
  end

endmodule

// ===== design/bchr_srch.sv =====
// Sequential search over single flips, then pairs, using the bit remainder table.
`timescale 1ns / 1ps

module bchr_srch (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bchr_pkg::tbl_wr_t                     tbl_wr,
  input  logic                                  start,
  input  logic [bchr_pkg::MAX_WORD_BITS-1:0]    rem,
  input  logic [bchr_pkg::MAX_WORD_BITS-1:0]    word,
  input  logic [bchr_pkg::WB_BITS-1:0]          n,
  input  logic                                  pair_en,
  output logic                                  done,
  output logic [bchr_pkg::MAX_WORD_BITS-1:0]    fixed,
  output logic [bchr_pkg::STATUS_BITS-1:0]      status
);

  localparam int W = bchr_pkg::MAX_WORD_BITS;
  localparam int I = bchr_pkg::IDX_BITS;

  bchr_pkg::srch_state_t state, state_next;

  logic [W-1:0] tbl [W];
  logic [W-1:0] rd_data;
  logic [I-1:0] rd_addr;
  logic         issue;
  logic         issue_load;
  logic         scanning;

  logic [I-1:0] i;
  logic [I-1:0] j;
  logic         q_valid;
  logic         q_load;
  logic         q_pair;
  logic [I-1:0] q_i;
  logic [I-1:0] q_j;
  logic [W-1:0] base;
  logic         hit;
  logic         last_j;
  logic [W-1:0] mask_i;
  logic [W-1:0] mask_j;

  always_ff @(posedge clk) begin
    if (tbl_wr.we) begin
      tbl[tbl_wr.addr] <= tbl_wr.data;
    end
    rd_data <= tbl[rd_addr];
  end

  always_comb begin
    issue      = 1'b0;
    issue_load = 1'b0;
    scanning   = 1'b0;
    done       = 1'b0;
    rd_addr    = j;
    unique case (state)
      bchr_pkg::SR_IDLE: ;
      bchr_pkg::SR_SINGLE: begin
        issue    = 1'b1;
        scanning = 1'b1;
      end
      bchr_pkg::SR_LOAD: begin
        issue      = 1'b1;
        issue_load = 1'b1;
        scanning   = 1'b1;
        rd_addr    = i;
      end
      bchr_pkg::SR_PAIR: begin
        issue    = 1'b1;
        scanning = 1'b1;
      end
      bchr_pkg::SR_DRAIN: scanning = 1'b1;
      bchr_pkg::SR_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  assign hit    = scanning && q_valid && !q_load && ((base ^ rd_data) == '0);
  assign last_j = (j == n - 5'd1);
  assign mask_i = W'(1) << (n - 5'd1 - q_i);
  assign mask_j = W'(1) << (n - 5'd1 - q_j);

  always_comb begin
    state_next = state;
    unique case (state)
      bchr_pkg::SR_IDLE: begin
        if (start) begin
          state_next = (rem == '0) ? bchr_pkg::SR_DONE : bchr_pkg::SR_SINGLE;
        end
      end
      bchr_pkg::SR_SINGLE: begin
        if (hit) begin
          state_next = bchr_pkg::SR_DONE;
        end else if (last_j) begin
          state_next = (pair_en && n >= 5'd2) ? bchr_pkg::SR_LOAD : bchr_pkg::SR_DRAIN;
        end
      end
      bchr_pkg::SR_LOAD: begin
        state_next = hit ? bchr_pkg::SR_DONE : bchr_pkg::SR_PAIR;
      end
      bchr_pkg::SR_PAIR: begin
        if (hit) begin
          state_next = bchr_pkg::SR_DONE;
        end else if (last_j) begin
          state_next = (i == n - 5'd2) ? bchr_pkg::SR_DRAIN : bchr_pkg::SR_LOAD;
        end
      end
      bchr_pkg::SR_DRAIN: state_next = hit ? bchr_pkg::SR_DONE : bchr_pkg::SR_DONE;
      bchr_pkg::SR_DONE:  state_next = bchr_pkg::SR_IDLE;
      default:            state_next = bchr_pkg::SR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bchr_pkg::SR_IDLE;
      q_valid <= 1'b0;
    end else begin
      state   <= state_next;
      q_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    q_load <= issue_load;
    q_pair <= (state == bchr_pkg::SR_PAIR);
    q_i    <= i;
    q_j    <= j;
    if (state == bchr_pkg::SR_IDLE && start) begin
      i      <= '0;
      j      <= '0;
      base   <= rem;
      fixed  <= word;
      status <= (rem == '0) ? bchr_pkg::ST_CLEAN : bchr_pkg::ST_FAIL;
    end else begin
      case (state)
        bchr_pkg::SR_SINGLE: j <= j + 5'd1;
        bchr_pkg::SR_LOAD:   j <= i + 5'd1;
        bchr_pkg::SR_PAIR: begin
          j <= j + 5'd1;
          if (last_j) begin
            i <= i + 5'd1;
          end
        end
        default: ;
      endcase
      if (scanning && q_valid && q_load) begin
        base <= rem ^ rd_data;
      end
      if (hit) begin
        fixed  <= word ^ mask_j ^ (q_pair ? mask_i : '0);
        status <= q_pair ? bchr_pkg::ST_TWO : bchr_pkg::ST_ONE;
      end
    end
  end

`ifndef SYNTH
  a_pair_enabled: assert property (@(posedge clk) disable iff (rst)
    state == bchr_pkg::SR_PAIR |-> pair_en)
    else $error("pair search running with pair correction off");
`endif

endmodule

// ===== design/bch_two_error_repair_top.sv =====
// Top level of the two-error BCH repair block: registers, sequencing and output stage.
//
//  channel   signals                               direction
//  word      word_valid, word_stall, received_word in
//  result    result_valid, result_stall, corrected_word, status, syndrome  out
//  config    cfg_we, cfg_index, cfg_data           in
//
// One transaction at a time; n is word_bits. The divider steps over all 31 bit positions
// whatever n is; the search then skips its loop when clean, else tries single flips and,
// with pairs enabled, flip pairs (single-port table read, one check a cycle), and the result
// goes through the output stage. At n = 0 the divider and search are skipped, and the next
// word can be accepted from the cycle after the result is loaded.
// Reset is synchronous and clears control only; the config registers take their defaults.
// A stalled result holds in the output register while the next word is accepted.
`timescale 1ns / 1ps

module bch_two_error_repair_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    word_valid,
  output logic                                    word_stall,
  input  logic [bchr_pkg::MAX_WORD_BITS-1:0]      received_word,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic [bchr_pkg::MAX_WORD_BITS-1:0]      corrected_word,
  output logic [bchr_pkg::STATUS_BITS-1:0]        status,
  output logic [bchr_pkg::SYN_BITS-1:0]           syndrome,
  input  logic                                    cfg_we,
  input  logic [bchr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [bchr_pkg::POLY_BITS-1:0]          cfg_data
);

  localparam int W = bchr_pkg::MAX_WORD_BITS;

  bchr_pkg::top_state_t state, state_next;

  logic [bchr_pkg::POLY_BITS-1:0]   gen_poly;
  logic [bchr_pkg::WB_BITS-1:0]     word_bits;
  logic [bchr_pkg::ME_BITS-1:0]     max_errors;

  logic                             word_acc;
  logic                             out_free;
  logic                             div_done;
  logic [W-1:0]                     div_rem;
  logic [W-1:0]                     div_masked;
  bchr_pkg::tbl_wr_t                tbl_wr;
  logic                             srch_done;
  logic [W-1:0]                     srch_fixed;
  logic [bchr_pkg::STATUS_BITS-1:0] srch_status;

  logic [W-1:0]                     pend_word;
  logic [bchr_pkg::STATUS_BITS-1:0] pend_status;
  logic [bchr_pkg::SYN_BITS-1:0]    pend_syn;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_poly   <= bchr_pkg::GEN_POLY_RESET;
      word_bits  <= bchr_pkg::WORD_BITS_RESET;
      max_errors <= bchr_pkg::MAX_ERRORS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bchr_pkg::REG_GEN_POLY:   gen_poly   <= cfg_data;
        bchr_pkg::REG_WORD_BITS:  word_bits  <= cfg_data[bchr_pkg::WB_BITS-1:0];
        bchr_pkg::REG_MAX_ERRORS: max_errors <= cfg_data[bchr_pkg::ME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign word_acc = word_valid && !word_stall;
  assign out_free = !result_valid || !result_stall;

  bchr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (word_acc && (word_bits != '0)),
    .word     (received_word),
    .n        (word_bits),
    .gen_poly (gen_poly),
    .done     (div_done),
    .rem      (div_rem),
    .masked   (div_masked),
    .tbl_wr   (tbl_wr)
  );

  bchr_srch u_srch (
    .clk     (clk),
    .rst     (rst),
    .tbl_wr  (tbl_wr),
    .start   (div_done),
    .rem     (div_rem),
    .word    (div_masked),
    .n       (word_bits),
    .pair_en (max_errors[1]),
    .done    (srch_done),
    .fixed   (srch_fixed),
    .status  (srch_status)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      bchr_pkg::TOP_IDLE: begin
        if (word_acc) begin
          state_next = (word_bits == '0) ? bchr_pkg::TOP_HOLD : bchr_pkg::TOP_DIV;
        end
      end
      bchr_pkg::TOP_DIV:  if (div_done)  state_next = bchr_pkg::TOP_SRCH;
      bchr_pkg::TOP_SRCH: if (srch_done) state_next = bchr_pkg::TOP_HOLD;
      bchr_pkg::TOP_HOLD: if (out_free)  state_next = bchr_pkg::TOP_IDLE;
      default: state_next = bchr_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    word_stall = 1'b1;
    unique case (state)
      bchr_pkg::TOP_IDLE: word_stall = 1'b0;
      bchr_pkg::TOP_DIV,
      bchr_pkg::TOP_SRCH,
      bchr_pkg::TOP_HOLD: word_stall = 1'b1;
      default:            word_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bchr_pkg::TOP_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bchr_pkg::TOP_HOLD && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bchr_pkg::TOP_IDLE && word_acc) begin
      pend_word   <= '0;
      pend_status <= bchr_pkg::ST_FAIL;
      pend_syn    <= '0;
    end else if (state == bchr_pkg::TOP_SRCH && srch_done) begin
      pend_word   <= srch_fixed;
      pend_status <= srch_status;
      pend_syn    <= div_rem[bchr_pkg::SYN_BITS-1:0];
    end
    if (state == bchr_pkg::TOP_HOLD && out_free) begin
      corrected_word <= pend_word;
      status         <= pend_status;
      syndrome       <= pend_syn;
    end
  end

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == bchr_pkg::TOP_DIV)
    else $error("divider finished outside the divide phase");

  a_srch_done_in_srch: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> state == bchr_pkg::TOP_SRCH)
    else $error("search finished outside the search phase");

  a_clean_zero_syn: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == bchr_pkg::ST_CLEAN |-> syndrome == '0)
    else $error("clean result with non-zero syndrome");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    word_acc |=> state != bchr_pkg::TOP_IDLE)
    else $error("accepted word did not start work");
`endif

endmodule

// ===== tb/bch_two_error_repair_top_tb.sv =====
// Self-checking testbench for the two-error BCH repair block: directed cases then random traffic.
`timescale 1ns / 1ps

module bch_two_error_repair_top_tb;

  localparam int MW = bchr_pkg::MAX_WORD_BITS;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [bchr_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [MW-1:0]                    corrected_word;
    logic [bchr_pkg::STATUS_BITS-1:0] status;
    logic [bchr_pkg::SYN_BITS-1:0]    syndrome;
  } repair_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              word_valid = 1'b0;
  logic                              word_stall;
  logic [MW-1:0]                     received_word = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic [MW-1:0]                     corrected_word;
  logic [bchr_pkg::STATUS_BITS-1:0]  status;
  logic [bchr_pkg::SYN_BITS-1:0]     syndrome;
  logic                              cfg_we = 1'b0;
  logic [bchr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [bchr_pkg::POLY_BITS-1:0]    cfg_data = '0;

  logic [bchr_pkg::POLY_BITS-1:0] gp_cfg = bchr_pkg::GEN_POLY_RESET;
  logic [bchr_pkg::WB_BITS-1:0]   wb_cfg = bchr_pkg::WORD_BITS_RESET;
  logic [bchr_pkg::ME_BITS-1:0]   me_cfg = bchr_pkg::MAX_ERRORS_RESET;

  repair_t repair_q[$];
  repair_t due_res;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_pct = 0;
  int      recv_pct = 0;

  bch_two_error_repair_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .received_word  (received_word),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .corrected_word (corrected_word),
    .status         (status),
    .syndrome       (syndrome),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [MW-1:0] word_mask(int n);
    logic [MW-1:0] m;
    m = '1;
    if (n == 0) return '0;
    return m >> (MW - n);
  endfunction

  function automatic logic [MW-1:0] gf2_rem(logic [MW-1:0] num,
                                            logic [bchr_pkg::POLY_BITS-1:0] poly);
    int plen;
    logic [MW-1:0] p;
    logic [MW-1:0] r;
    plen = 0;
    for (int b = 0; b < bchr_pkg::POLY_BITS; b++) if (poly[b]) plen = b + 1;
    r = num;
    p = '0;
    p[bchr_pkg::POLY_BITS-1:0] = poly;
    if (plen == 0) return r;
    for (int b = MW - 1; b >= plen - 1; b--) begin
      if (r[b]) r ^= p << (b - plen + 1);
    end
    return r;
  endfunction

  // remainder is linear over GF(2), so flip checks use per-bit remainders
  function automatic repair_t predict_repair(logic [MW-1:0] rx);
    repair_t r;
    logic [MW-1:0] w;
    logic [MW-1:0] s;
    logic [MW-1:0] one;
    logic [MW-1:0] bit_rem [0:MW-1];
    int n;
    bit found;
    n = int'(wb_cfg);
    one = MW'(1);
    found = 1'b0;
    if (n == 0) begin
      r.corrected_word = '0;
      r.status = bchr_pkg::ST_FAIL;
      r.syndrome = '0;
      return r;
    end
    w = rx & word_mask(n);
    s = gf2_rem(w, gp_cfg);
    r.corrected_word = w;
    r.syndrome = s[bchr_pkg::SYN_BITS-1:0];
    r.status = bchr_pkg::ST_FAIL;
    if (s == '0) begin
      r.status = bchr_pkg::ST_CLEAN;
      return r;
    end
    for (int k = 0; k < n; k++) bit_rem[k] = gf2_rem(one << (n - 1 - k), gp_cfg);
    for (int k = 0; k < n && !found; k++) begin
      if (bit_rem[k] == s) begin
        r.corrected_word = w ^ (one << (n - 1 - k));
        r.status = bchr_pkg::ST_ONE;
        found = 1'b1;
      end
    end
    if (!found && me_cfg >= 2) begin
      for (int i = 0; i < n && !found; i++) begin
        for (int j = i + 1; j < n && !found; j++) begin
          if ((s ^ bit_rem[i] ^ bit_rem[j]) == '0) begin
            r.corrected_word = w ^ (one << (n - 1 - i)) ^ (one << (n - 1 - j));
            r.status = bchr_pkg::ST_TWO;
            found = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] codeword_of(logic [MW-1:0] seed);
    logic [MW-1:0] w;
    w = seed & word_mask(int'(wb_cfg));
    return w ^ gf2_rem(w, gp_cfg);
  endfunction

  function automatic logic [MW-1:0] bit_at(int idx);
    logic [MW-1:0] one;
    one = MW'(1);
    return one << (int'(wb_cfg) - 1 - idx);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bch_two_error_repair_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (repair_q.size() == 0) begin
        $error("result transaction with nothing outstanding: corrected_word %h", corrected_word);
        fail_count++;
      end else begin
        due_res = repair_q.pop_front();
        if (corrected_word !== due_res.corrected_word) begin
          $error("corrected_word: expected %h, got %h", due_res.corrected_word, corrected_word);
          fail_count++;
        end
        if (status !== due_res.status) begin
          $error("status: expected %0d, got %0d", due_res.status, status);
          fail_count++;
        end
        if (syndrome !== due_res.syndrome) begin
          $error("syndrome: expected %h, got %h", due_res.syndrome, syndrome);
          fail_count++;
        end
      end
    end
    result_stall <= ($urandom_range(99) < recv_pct);
  end

  task automatic send_word(input logic [MW-1:0] w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_valid <= 1'b1;
    received_word <= w;
    @(posedge clk);
    while (word_stall) @(posedge clk);
    repair_q.push_back(predict_repair(w));
  endtask

  task automatic drain;
    word_valid <= 1'b0;
    while (repair_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bchr_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bchr_pkg::POLY_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      bchr_pkg::REG_GEN_POLY:   gp_cfg = data;
      bchr_pkg::REG_WORD_BITS:  wb_cfg = data[bchr_pkg::WB_BITS-1:0];
      bchr_pkg::REG_MAX_ERRORS: me_cfg = data[bchr_pkg::ME_BITS-1:0];
      default: ;
    endcase
  endtask

  // upper data bits beyond each register's width are junk and must be dropped
  task automatic set_config(input logic [bchr_pkg::POLY_BITS-1:0] gp,
                            input logic [bchr_pkg::WB_BITS-1:0] wb,
                            input logic [bchr_pkg::ME_BITS-1:0] me);
    logic [bchr_pkg::POLY_BITS-bchr_pkg::WB_BITS-1:0] hi_wb;
    logic [bchr_pkg::POLY_BITS-bchr_pkg::ME_BITS-1:0] hi_me;
    hi_wb = (bchr_pkg::POLY_BITS-bchr_pkg::WB_BITS)'($urandom);
    hi_me = (bchr_pkg::POLY_BITS-bchr_pkg::ME_BITS)'($urandom);
    drain();
    cfg_write(bchr_pkg::REG_GEN_POLY, gp);
    cfg_write(bchr_pkg::REG_WORD_BITS, {hi_wb, wb});
    cfg_write(bchr_pkg::REG_MAX_ERRORS, {hi_me, me});
    cfg_write(REG_UNUSED, bchr_pkg::POLY_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults;
    logic [MW-1:0] cw;
    drain();
    cw = codeword_of(MW'($urandom));
    send_word('0);
    send_word('1);
    send_word(cw);
    send_word(cw ^ bit_at(0));
    send_word(cw ^ bit_at(30));
    send_word(cw ^ bit_at(0) ^ bit_at(1));
    send_word(cw ^ bit_at(29) ^ bit_at(30));
    send_word(cw ^ bit_at(3) ^ bit_at(11) ^ bit_at(25));
  endtask

  task automatic test_word_length_edges;
    logic [MW-1:0] cw;
    set_config(bchr_pkg::GEN_POLY_RESET, 5'd1, 2'd2);
    send_word(31'h7FFF_FFFE);
    send_word(31'h0000_0001);
    set_config(bchr_pkg::GEN_POLY_RESET, 5'd0, 2'd2);
    send_word('1);
    send_word(31'h2A5A_C3E1);
    set_config(12'hFFF, 5'd31, 2'd2);
    cw = codeword_of(MW'($urandom));
    send_word(cw ^ bit_at(7) ^ bit_at(20));
    set_config(12'hFFF, 5'd1, 2'd2);
    send_word(31'h0000_0001);
  endtask

  task automatic test_degenerate_polys;
    set_config('0, 5'd31, 2'd2);
    send_word('0);
    send_word(31'h0000_4000);
    send_word(31'h4000_0001);
    send_word(31'h0000_0007);
    send_word(31'h0000_07FF);
    set_config(12'd1, 5'd31, 2'd2);
    send_word(31'h5A5A_5A5A);
    send_word('1);
  endtask

  task automatic test_error_limits;
    logic [MW-1:0] cw;
    set_config(bchr_pkg::GEN_POLY_RESET, 5'd31, 2'd0);
    cw = codeword_of(MW'($urandom));
    send_word(cw ^ bit_at(2) ^ bit_at(17));
    send_word(cw ^ bit_at(9));
    set_config(bchr_pkg::GEN_POLY_RESET, 5'd31, 2'd1);
    send_word(cw ^ bit_at(5) ^ bit_at(6));
    set_config(bchr_pkg::GEN_POLY_RESET, 5'd31, 2'd3);
    send_word(cw ^ bit_at(5) ^ bit_at(6));
    set_config(12'd3, 5'd31, 2'd2);
    send_word(31'h0000_0001);
    send_word(31'h0000_0003);
  endtask

  task automatic run_random_phase(input logic [bchr_pkg::POLY_BITS-1:0] gp,
                                  input logic [bchr_pkg::WB_BITS-1:0] wb,
                                  input logic [bchr_pkg::ME_BITS-1:0] me, input int count,
                                  input int mode);
    logic [MW-1:0] w;
    logic [MW-1:0] fm;
    int n;
    int k;
    int r;
    set_config(gp, wb, me);
    send_pct = (mode == 1) ? 59 : (mode == 3) ? 6 : 0;
    recv_pct = (mode == 2) ? 59 : (mode == 3) ? 6 : 0;
    n = int'(wb_cfg);
    for (int c = 0; c < count; c++) begin
      if ($urandom_range(3) == 0) begin
        w = MW'($urandom);
      end else begin
        w = codeword_of(MW'($urandom));
        r = int'($urandom_range(99));
        k = (r < 20) ? 0 : (r < 55) ? 1 : (r < 90) ? 2 : 3;
        if (k > n) k = n;
        fm = '0;
        while ($countones(fm) < k) fm[$urandom_range(n - 1)] = 1'b1;
        w ^= fm;
        if ($urandom_range(1) == 1) w |= ~word_mask(n) & MW'($urandom);
      end
      send_word(w);
    end
  endtask

  task automatic test_random_traffic;
    logic [bchr_pkg::POLY_BITS-1:0] gp;
    logic [bchr_pkg::WB_BITS-1:0]   wb;
    logic [bchr_pkg::ME_BITS-1:0]   me;
    for (int ph = 0; ph < 12; ph++) begin
      gp = bchr_pkg::POLY_BITS'($urandom_range(4095));
      wb = ($urandom_range(9) == 0) ? 5'd31 : bchr_pkg::WB_BITS'($urandom_range(16, 1));
      me = bchr_pkg::ME_BITS'($urandom_range(3));
      case (ph)
        0: begin
          gp = bchr_pkg::GEN_POLY_RESET;
          wb = 5'd31;
          me = 2'd2;
        end
        1: begin
          gp = 12'hFFF;
          wb = 5'd31;
          me = 2'd3;
        end
        3: begin
          gp = 12'd3;
          wb = 5'd20;
          me = 2'd1;
        end
        4: gp = '0;
        5: gp = 12'd1;
        6: wb = 5'd0;
        default: ;
      endcase
      run_random_phase(gp, wb, me, 95, ph % 4);
    end
    send_pct = 0;
    recv_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_word_length_edges();
    test_degenerate_polys();
    test_error_limits();
    test_random_traffic();
    drain();
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("bch_two_error_repair_top_tb passed");
    end else begin
      $display("bch_two_error_repair_top_tb failed");
    end
    $finish;
  end

endmodule
